[rtl/wcsf_pkg.sv]
// ---------------------------------------------------------------------------
// wcsf_pkg
// shared constants and types of the weighted cross smoothing filter
// ---------------------------------------------------------------------------
package wcsf_pkg;

	localparam int MAX_WIDTH        = 1024;
	localparam int MAX_HEIGHT       = 4096;
	localparam int WEIGHT_FRAC_BITS = 8;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int FW_W     = 11;
	localparam int FH_W     = 13;
	localparam int ROW_W    = 13;
	localparam int WGT_W    = 12;
	localparam int PIX_W    = 32;
	localparam int SUM_W    = 11;
	localparam int DEN_W    = 15;
	localparam int NUM_W    = 23;
	localparam int DIV_STEPS = 8;
	localparam int STEP_W   = $clog2(DIV_STEPS);

	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_NEIGH_WEIGHT = 2'd2;
	localparam logic [1:0] CFG_ALPHA_EN     = 2'd3;

	localparam logic CMD_FLUSH = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_PUSH = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic step;
	} lane_ctl_t;

	typedef struct packed {
		logic use_l;
		logic use_r;
		logic use_a;
		logic use_b;
	} nbr_use_t;

endpackage

[rtl/wcsf_ram.sv]
// ---------------------------------------------------------------------------
// wcsf_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module wcsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/wcsf_lane.sv]
// ---------------------------------------------------------------------------
// wcsf_lane
// one color channel: weighted numerator and bit-serial quotient
// ---------------------------------------------------------------------------
module wcsf_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wcsf_pkg::lane_ctl_t       ctl,
	input  wcsf_pkg::nbr_use_t        use_n,
	input  logic [7:0]                centre,
	input  logic [7:0]                left,
	input  logic [7:0]                right,
	input  logic [7:0]                above,
	input  logic [7:0]                below,
	input  logic [wcsf_pkg::WGT_W-1:0] weight,
	input  logic [wcsf_pkg::DEN_W-1:0] den,
	output logic [7:0]                quot
);
	import wcsf_pkg::*;

	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-1:0] sum_q;
	logic [7:0]       centre_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dv_q;
	logic [7:0]       quot_q;

	// centre counts once more with weight, once with unit weight
	always_comb begin
		sum_c = SUM_W'(centre);
		if (use_n.use_l) sum_c = sum_c + SUM_W'(left);
		if (use_n.use_r) sum_c = sum_c + SUM_W'(right);
		if (use_n.use_a) sum_c = sum_c + SUM_W'(above);
		if (use_n.use_b) sum_c = sum_c + SUM_W'(below);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
		end else if (ctl.mul) begin
			quot_q <= '0;
		end else if (ctl.step) begin
			quot_q <= {quot_q[6:0], (rem_q >= dv_q)};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sum_q    <= sum_c;
			centre_q <= centre;
			den_q    <= den;
		end
		if (ctl.mul) begin
			rem_q <= (NUM_W'(centre_q) << WEIGHT_FRAC_BITS) + NUM_W'(weight) * NUM_W'(sum_q);
			dv_q  <= NUM_W'(den_q) << (DIV_STEPS - 1);
		end else if (ctl.step) begin
			if (rem_q >= dv_q) rem_q <= rem_q - dv_q;
			dv_q <= dv_q >> 1;
		end
	end

	assign quot = quot_q;
endmodule

[rtl/weighted_cross_smoothing_filter.sv]
// ---------------------------------------------------------------------------
// weighted_cross_smoothing_filter
// five-point cross smoothing of an rgba raster stream
// ---------------------------------------------------------------------------
// Pixels come in raster order, one per transfer on s_axis; every frame must
// be followed by frame_width flush ticks (tuser = 1) to drain the last row.
// The result for stream item n leaves when item n + frame_width has been
// taken, so row 0 gives nothing and the flush row gives the last row. Each
// channel is (centre*(1+w) + w*sum of in-frame edge neighbours) divided by
// the sum of weights used, truncated; w is Q4.8. Items are handled one at a
// time: a pixel with a result goes through line store read, multiply, 8
// quotient bits from the bit-serial divider in each of the four channel
// lanes and output load, one without only the read, an ignored flush tick
// nothing. Line stores are 1024 x 32 rams, written as the row passes;
// configuration writes are taken at any time but belong in idle periods.
// ---------------------------------------------------------------------------
module weighted_cross_smoothing_filter (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
	input  logic        s_axis_tuser,   // cmd
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic        m_axis_tlast    // frame_end
);
	import wcsf_pkg::*;

	// configuration registers
	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [WGT_W-1:0] weight_q;
	logic             alpha_en_q;

	// raster position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	// item held in work
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] cur_s1;
	nbr_use_t         use_s1;
	logic             has_res_s1;
	logic             last_s1;
	logic [PIX_W-1:0] prev_centre_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_last_q;

	logic [FW_W-1:0]  w_eff;
	logic [FH_W-1:0]  h_eff;
	logic             flushing;
	logic             row_end;
	logic             s_xfer;
	logic             ignore;
	logic             out_free;
	logic [PIX_W-1:0] centre_rd;
	logic [PIX_W-1:0] above_rd;
	logic [PIX_W-1:0] right_rd;
	logic [2:0]       n_used;
	logic [DEN_W-1:0] den_c;
	lane_ctl_t        ctl;
	logic [7:0]       quot [4];
	logic             ram_we;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(MAX_WIDTH);
			frame_height_q <= FH_W'(1024);
			weight_q       <= WGT_W'(256);
			alpha_en_q     <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				CFG_NEIGH_WEIGHT: weight_q       <= cfg_data[WGT_W-1:0];
				CFG_ALPHA_EN:     alpha_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize is clamped
	always_comb begin
		w_eff = frame_width_q;
		if (frame_width_q == '0) w_eff = FW_W'(1);
		else if (frame_width_q > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
		h_eff = frame_height_q;
		if (frame_height_q == '0) h_eff = FH_W'(1);
		else if (frame_height_q > FH_W'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
	end

	assign flushing      = row_q >= ROW_W'(h_eff);
	assign row_end       = (FW_W'(col_q) + FW_W'(1)) >= w_eff;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_xfer        = s_axis_tvalid && s_axis_tready;
	// flush tick while pixel rows are still coming: no effect at all
	assign ignore        = !flushing && (s_axis_tuser == CMD_FLUSH);
	assign out_free      = !out_valid_q || m_axis_tready;

	// position counters and item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_xfer && !ignore) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= flushing ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && !ignore) begin
			col_s1       <= col_q;
			cur_s1       <= flushing ? '0 : s_axis_tdata;
			use_s1.use_l <= col_q != '0;
			use_s1.use_r <= !row_end;
			use_s1.use_a <= row_q >= ROW_W'(2);
			use_s1.use_b <= !flushing;
			has_res_s1   <= row_q != '0;
			last_s1      <= flushing && row_end;
		end
		// left neighbour is the centre of the previous item
		if (state_q == ST_RD) prev_centre_q <= centre_rd;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_xfer && !ignore) state_q <= ST_RD;
				ST_RD:   state_q <= has_res_s1 ? ST_MUL : ST_IDLE;
				ST_MUL: begin
					state_q <= ST_DIV;
					step_q  <= '0;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= ST_PUSH;
				end
				ST_PUSH: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// line stores: the middle row is kept twice for the centre and right reads
	assign ram_we = (state_q == ST_RD);

	wcsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_centre (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (cur_s1),
		.raddr (col_q),
		.rdata (centre_rd)
	);

	wcsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_right (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (cur_s1),
		.raddr (col_q + COL_W'(1)),
		.rdata (right_rd)
	);

	wcsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (centre_rd),
		.raddr (col_q),
		.rdata (above_rd)
	);

	// divisor: one + (neighbours used + 1) * w
	assign n_used = 3'(use_s1.use_l) + 3'(use_s1.use_r) + 3'(use_s1.use_a)
		+ 3'(use_s1.use_b) + 3'd1;
	assign den_c  = (DEN_W'(1) << WEIGHT_FRAC_BITS) + DEN_W'(n_used) * DEN_W'(weight_q);

	assign ctl.load = (state_q == ST_RD);
	assign ctl.mul  = (state_q == ST_MUL);
	assign ctl.step = (state_q == ST_DIV);

	for (genvar g = 0; g < 4; g++) begin : g_lane
		wcsf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.use_n  (use_s1),
			.centre (centre_rd[8*g +: 8]),
			.left   (prev_centre_q[8*g +: 8]),
			.right  (right_rd[8*g +: 8]),
			.above  (above_rd[8*g +: 8]),
			.below  (cur_s1[8*g +: 8]),
			.weight (weight_q),
			.den    (den_c),
			.quot   (quot[g])
		);
	end

	// merge the lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			out_data_q <= {alpha_en_q ? quot[3] : 8'hFF, quot[2], quot[1], quot[0]};
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
endmodule

[rtl/wcsf_checker.sv]
// ---------------------------------------------------------------------------
// wcsf_checker
// port-level checks of the smoothing filter
// ---------------------------------------------------------------------------
module wcsf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	// one item at a time: a pixel transfer is never followed by another at once
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
		else $error("input taken on back-to-back cycles");

	// no result before the item that causes it has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result appeared with no item in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");
endmodule

bind weighted_cross_smoothing_filter wcsf_checker u_wcsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the weighted cross smoothing filter
// ---------------------------------------------------------------------------
// Whole frames of random rgba pixels, each closed by its flush row, are sent
// under changing geometry, weight and alpha settings. A scoreboard keeps its
// own line stores and counters, predicts every smoothed pixel and compares
// each output transfer field by field, in order.
// ---------------------------------------------------------------------------
module tb_top;
	import wcsf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int LONG_HOLD      = 400;

	typedef struct packed {
		logic [31:0] px;
		logic        last;
	} smoothed_t;

	// scoreboard: mirror of the filter state plus the queue of pending pixels
	class smoothing_board;
		bit [10:0] width_reg  = 11'd1024;
		bit [12:0] height_reg = 13'd1024;
		bit [11:0] weight_reg = 12'd256;
		bit        alpha_reg  = 1'b1;
		bit [31:0] row_above [MAX_WIDTH];
		bit [31:0] row_mid [MAX_WIDTH];
		bit [31:0] win_prev, win_cur;
		int unsigned col, row;
		smoothed_t pending_px[$];
		int errors, matched;

		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void set_reg(logic [1:0] idx, logic [12:0] val);
			case (idx)
				CFG_FRAME_WIDTH: width_reg = val[10:0];
				CFG_FRAME_HEIGHT: height_reg = val[12:0];
				CFG_NEIGH_WEIGHT: weight_reg = val[11:0];
				CFG_ALPHA_EN: alpha_reg = val[0];
				default: ;
			endcase
		endfunction

		// runs one accepted input through the predictor
		function void note_input(logic cmd, logic [31:0] data);
			int unsigned wpx, hpx, c, k, one, w, den, num;
			bit flushing, use_l, use_r, use_a, use_b;
			bit [31:0] cur, centre, above, right_px, left_px;
			smoothed_t res;
			wpx = eff_width();
			hpx = eff_height();
			flushing = row >= hpx;
			if (!flushing && cmd == CMD_FLUSH)
				return;
			cur = flushing ? 32'd0 : data;
			c = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
			centre = row_mid[c];
			above = row_above[c];
			right_px = (c + 1 < MAX_WIDTH) ? row_mid[c + 1] : 32'd0;
			win_prev = win_cur;
			win_cur = centre;
			left_px = win_prev;
			row_above[c] = centre;
			row_mid[c] = cur;
			if (row >= 1) begin
				one = 1 << WEIGHT_FRAC_BITS;
				w = weight_reg;
				use_l = c > 0;
				use_r = c + 1 < wpx;
				use_a = row >= 2;
				use_b = !flushing;
				k = use_l + use_r + use_a + use_b;
				den = one + (k + 1) * w;
				for (int ch = 0; ch < 4; ch++) begin
					num = centre[8*ch +: 8] * (one + w);
					if (use_l) num += left_px[8*ch +: 8] * w;
					if (use_r) num += right_px[8*ch +: 8] * w;
					if (use_a) num += above[8*ch +: 8] * w;
					if (use_b) num += cur[8*ch +: 8] * w;
					res.px[8*ch +: 8] = num / den;
				end
				if (!alpha_reg) res.px[31:24] = 8'hff;
				res.last = flushing && (c + 1 >= wpx);
				pending_px.push_back(res);
			end
			if (c + 1 >= wpx) begin
				col = 0;
				row = flushing ? 0 : row + 1;
			end else begin
				col = c + 1;
			end
		endfunction

		function void check_result(logic [31:0] px, logic last);
			smoothed_t exp_px;
			bit bad;
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected output pixel %h last %b", $time, px, last);
				errors++;
				return;
			end
			exp_px = pending_px.pop_front();
			bad = 0;
			for (int ch = 0; ch < 4; ch++)
				if (px[8*ch +: 8] !== exp_px.px[8*ch +: 8]) begin
					$display("%0t: channel %0d expected %h actual %h",
						$time, ch, exp_px.px[8*ch +: 8], px[8*ch +: 8]);
					bad = 1;
				end
			if (last !== exp_px.last) begin
				$display("%0t: frame_end expected %b actual %b", $time, exp_px.last, last);
				bad = 1;
			end
			if (bad) errors++;
			else matched++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // in_red, in_green, in_blue, in_alpha
	logic        s_axis_tuser;   // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // out_red, out_green, out_blue, out_alpha
	logic        m_axis_tlast;   // frame_end

	smoothing_board sb = new;

	int tx_idle_pct, rx_idle_pct;
	int items_sent, frames_sent, idle_cycles;
	bit hold_toggle, hold_seen;
	int hold_left;

	weighted_cross_smoothing_filter uut (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check every transfer, stall at random or for a long hold
	// that starts once a result is waiting
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast);
		if (hold_toggle != hold_seen && m_axis_tvalid) begin
			hold_seen <= hold_toggle;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, nothing moved for %0d cycles", $time, idle_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// one input transfer, with random gaps in front of it
	task automatic send_item(logic cmd, logic [31:0] data);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(cmd, data);
		items_sent++;
	endtask

	// pause the sender until every expected pixel has left and the block idles
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after its last write
	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	function automatic logic [31:0] rand_pixel();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return {4{$urandom_range(1) ? 8'haa : 8'h55}};
			default: return $urandom;
		endcase
	endfunction

	// a full frame plus its flush row; noise adds ignored flush ticks during
	// the pixel rows and pixels offered in place of flush ticks
	task automatic run_frame(int w_reg, int h_reg, int wgt, bit alpha, bit noise);
		int wpx, hpx;
		drain();
		write_reg(CFG_FRAME_WIDTH, 13'(w_reg));
		write_reg(CFG_FRAME_HEIGHT, 13'(h_reg));
		write_reg(CFG_NEIGH_WEIGHT, 13'(wgt));
		write_reg(CFG_ALPHA_EN, 13'(alpha));
		cfg_valid <= 1'b0;
		wpx = sb.eff_width();
		hpx = sb.eff_height();
		for (int i = 0; i < wpx * hpx; i++) begin
			if (noise && $urandom_range(99) < 6)
				send_item(CMD_FLUSH, $urandom);
			send_item(~CMD_FLUSH, rand_pixel());
		end
		for (int i = 0; i < wpx; i++)
			if (noise && $urandom_range(99) < 15)
				send_item(~CMD_FLUSH, $urandom);
			else
				send_item(CMD_FLUSH, $urandom);
		frames_sent++;
	endtask

	task automatic random_phase(int tx_pct, int rx_pct, int quota);
		int w, h, wgt;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (quota > 0) begin
			case ($urandom_range(19))
				0: w = $urandom_range(41, 120);
				1, 2, 3: w = $urandom_range(9, 40);
				default: w = $urandom_range(1, 8);
			endcase
			h = $urandom_range(1, 6);
			case ($urandom_range(5))
				0: wgt = 0;
				1: wgt = 4095;
				default: wgt = $urandom_range(4095);
			endcase
			run_frame(w, h, wgt, 1'($urandom_range(1)), $urandom_range(3) != 0);
			quota -= w * (h + 1);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= ~CMD_FLUSH;
		s_axis_tdata <= '0;
		hold_toggle = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small frames at the weight extremes, alpha both ways,
		// a lone pixel and a single row
		run_frame(3, 3, 4095, 1, 1);
		run_frame(3, 2, 0, 0, 0);
		run_frame(1, 1, 256, 1, 0);
		run_frame(4, 1, 4095, 0, 1);

		// long receiver hold on the first result of a frame while the
		// sender keeps offering the rest of it
		drain();
		hold_toggle = ~hold_toggle;
		run_frame(8, 4, 300, 1, 0);

		// sender gaps light, receiver stalls heavy
		random_phase(28, 66, 480);
		// a wide frame with height zero
		run_frame(200, 0, 4095, 1, 0);
		random_phase(66, 28, 480);
		run_frame(0, 5, 300, 1, 1);
		random_phase(0, 0, 480);

		drain();
		if (sb.pending_px.size() != 0) sb.errors++;
		$display("covered %0d input transfers over %0d frames, %0d pixels matched",
			items_sent, frames_sent, sb.matched);
		$display("geometry up to 200 wide, weights 0..4095, alpha on and off, flush noise");
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
